[rtl/duration_text_parser_macros.svh]
// assertion macros shared by the duration text parser rtl
// depends on nothing; included by files that carry concurrent assertions
`ifndef DURATION_TEXT_PARSER_MACROS_SVH
`define DURATION_TEXT_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DTP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("duration text parser assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DTP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("duration text parser assertion failed");

`endif

[rtl/dtp_pkg.sv]
// types and constants for the duration text parser
// no dependencies; used by duration_text_parser
package dtp_pkg;

	localparam int unsigned SYM_W  = 16;
	localparam int unsigned SECS_W = 31;
	// widths of the multiply-add results before the range check
	localparam int unsigned MAC_W  = 35;
	localparam int unsigned SUM_W  = 38;

	localparam logic [SECS_W-1:0] MAX_SECONDS = 31'h7FFF_FFFF;

	localparam logic [SYM_W-1:0] CHAR_0     = 16'h0030;
	localparam logic [SYM_W-1:0] CHAR_9     = 16'h0039;
	localparam logic [SYM_W-1:0] CHAR_COLON = 16'h003A;
	localparam logic [SYM_W-1:0] CHAR_M     = 16'h006D;
	localparam logic [SYM_W-1:0] CHAR_S     = 16'h0073;

	localparam logic [3:0] RADIX       = 4'd10;
	localparam logic [5:0] SECS_PER_MIN = 6'd60;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             end_marker;
	} item_t;

	typedef struct packed {
		logic [SECS_W-1:0] total_seconds;
		logic              valid_res;
	} result_t;

endpackage

[rtl/duration_text_parser.sv]
// duration text parser top level: character-serial parse to total seconds
// depends on dtp_pkg and duration_text_parser_macros.svh
// throughput: one transfer per cycle on the item channel, characters and end items alike,
//   but an end item stalls the channel while the result register is full and not drained
// end item path: input register, then result register; character transfers give no result
// reset: arst_n clears both valid flags and all parse state to zero
`include "duration_text_parser_macros.svh"

module duration_text_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  dtp_pkg::item_t  item,
	output logic            result_valid,
	input  logic            result_ready,
	output dtp_pkg::result_t result
);

	// input register
	dtp_pkg::item_t item_s1;
	logic           item_valid_s1;

	// colon reading state
	logic [dtp_pkg::SECS_W-1:0] colon_minutes_q, colon_minutes_d;
	logic                       colon_seen_q, colon_seen_d;
	logic [1:0]                 digits_after_colon_q, digits_after_colon_d;
	logic [6:0]                 colon_seconds_q, colon_seconds_d;
	logic                       colon_bad_q, colon_bad_d;

	// unit reading state
	logic [dtp_pkg::SECS_W-1:0] group_value_q, group_value_d;
	logic                       group_has_digit_q, group_has_digit_d;
	logic [dtp_pkg::SECS_W-1:0] unit_minutes_q, unit_minutes_d;
	logic [dtp_pkg::SECS_W-1:0] unit_seconds_q, unit_seconds_d;
	logic                       seen_min_q, seen_min_d;
	logic                       seen_sec_q, seen_sec_d;
	logic                       unit_bad_q, unit_bad_d;

	// result register
	dtp_pkg::result_t result_q, result_d;
	logic             result_valid_q;

	logic result_free;
	logic s1_advance;
	logic take_char;
	logic take_end;

	logic [dtp_pkg::SYM_W-1:0]  sym;
	logic                       is_digit;
	logic [3:0]                 digit_val;
	logic [dtp_pkg::MAC_W-1:0]  colon_mac;
	logic [dtp_pkg::MAC_W-1:0]  group_mac;
	logic [dtp_pkg::SECS_W-1:0] sel_minutes;
	logic [dtp_pkg::SECS_W-1:0] sel_seconds;
	logic [dtp_pkg::SUM_W-1:0]  total_wide;
	logic                       total_fits;
	logic                       parse_ok;

	// handshake: the input register moves on whenever its item is a character,
	// or it is an end item and the result register is empty or being drained
	assign result_free  = !result_valid_q || result_ready;
	assign s1_advance   = item_valid_s1 && (!item_s1.end_marker || result_free);
	assign item_ready   = !item_valid_s1 || s1_advance;
	assign take_char    = s1_advance && !item_s1.end_marker;
	assign take_end     = s1_advance && item_s1.end_marker;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// character classification
	assign sym       = item_s1.symbol;
	assign is_digit  = (sym >= dtp_pkg::CHAR_0) && (sym <= dtp_pkg::CHAR_9);
	assign digit_val = is_digit ? 4'(sym - dtp_pkg::CHAR_0) : 4'd0;

	// running decimal accumulators, times ten plus the new digit
	assign colon_mac = dtp_pkg::MAC_W'(colon_minutes_q) * dtp_pkg::MAC_W'(dtp_pkg::RADIX)
		+ dtp_pkg::MAC_W'(digit_val);
	assign group_mac = dtp_pkg::MAC_W'(group_value_q) * dtp_pkg::MAC_W'(dtp_pkg::RADIX)
		+ dtp_pkg::MAC_W'(digit_val);

	// end item: pick the reading, then one shared minutes * 60 + seconds
	assign sel_minutes = colon_seen_q ? colon_minutes_q : unit_minutes_q;
	assign sel_seconds = colon_seen_q ? dtp_pkg::SECS_W'(colon_seconds_q) : unit_seconds_q;
	assign total_wide  = dtp_pkg::SUM_W'(sel_minutes) * dtp_pkg::SUM_W'(dtp_pkg::SECS_PER_MIN)
		+ dtp_pkg::SUM_W'(sel_seconds);
	assign total_fits  = total_wide <= dtp_pkg::SUM_W'(dtp_pkg::MAX_SECONDS);

	always_comb begin
		if (colon_seen_q) begin
			parse_ok = !colon_bad_q && (digits_after_colon_q == 2'd2) && total_fits;
		end else begin
			parse_ok = !unit_bad_q && !group_has_digit_q && (seen_min_q || seen_sec_q)
				&& total_fits;
		end
		if (parse_ok) begin
			result_d.total_seconds = total_wide[dtp_pkg::SECS_W-1:0];
			result_d.valid_res     = 1'b1;
		end else begin
			result_d.total_seconds = dtp_pkg::MAX_SECONDS;
			result_d.valid_res     = 1'b0;
		end
	end

	// next parse state
	always_comb begin
		colon_minutes_d      = colon_minutes_q;
		colon_seen_d         = colon_seen_q;
		digits_after_colon_d = digits_after_colon_q;
		colon_seconds_d      = colon_seconds_q;
		colon_bad_d          = colon_bad_q;
		group_value_d        = group_value_q;
		group_has_digit_d    = group_has_digit_q;
		unit_minutes_d       = unit_minutes_q;
		unit_seconds_d       = unit_seconds_q;
		seen_min_d           = seen_min_q;
		seen_sec_d           = seen_sec_q;
		unit_bad_d           = unit_bad_q;

		if (take_end) begin
			// every end item starts a fresh text
			colon_minutes_d      = '0;
			colon_seen_d         = 1'b0;
			digits_after_colon_d = '0;
			colon_seconds_d      = '0;
			colon_bad_d          = 1'b0;
			group_value_d        = '0;
			group_has_digit_d    = 1'b0;
			unit_minutes_d       = '0;
			unit_seconds_d       = '0;
			seen_min_d           = 1'b0;
			seen_sec_d           = 1'b0;
			unit_bad_d           = 1'b0;
		end else if (take_char) begin
			// colon reading: minutes field, then exactly two seconds digits
			if (!colon_seen_q) begin
				if (is_digit) begin
					if (colon_mac > dtp_pkg::MAC_W'(dtp_pkg::MAX_SECONDS)) begin
						colon_bad_d = 1'b1;
					end
					colon_minutes_d = colon_mac[dtp_pkg::SECS_W-1:0];
				end else if (sym == dtp_pkg::CHAR_COLON) begin
					colon_seen_d = 1'b1;
				end else begin
					colon_bad_d = 1'b1;
				end
			end else if (is_digit && (digits_after_colon_q < 2'd2)) begin
				colon_seconds_d      = 7'(colon_seconds_q * 7'd10 + 7'(digit_val));
				digits_after_colon_d = digits_after_colon_q + 2'd1;
			end else begin
				colon_bad_d = 1'b1;
			end

			// unit reading: digit groups closed by m (once, before s) or s (once)
			if (is_digit) begin
				if (group_mac > dtp_pkg::MAC_W'(dtp_pkg::MAX_SECONDS)) begin
					unit_bad_d = 1'b1;
				end
				group_value_d     = group_mac[dtp_pkg::SECS_W-1:0];
				group_has_digit_d = 1'b1;
			end else if (sym == dtp_pkg::CHAR_M) begin
				if (group_has_digit_q && !seen_min_q && !seen_sec_q) begin
					unit_minutes_d = group_value_q;
					seen_min_d     = 1'b1;
				end else begin
					unit_bad_d = 1'b1;
				end
				group_value_d     = '0;
				group_has_digit_d = 1'b0;
			end else if (sym == dtp_pkg::CHAR_S) begin
				if (group_has_digit_q && !seen_sec_q) begin
					unit_seconds_d = group_value_q;
					seen_sec_d     = 1'b1;
				end else begin
					unit_bad_d = 1'b1;
				end
				group_value_d     = '0;
				group_has_digit_d = 1'b0;
			end else begin
				unit_bad_d = 1'b1;
			end
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colon_minutes_q      <= '0;
			colon_seen_q         <= 1'b0;
			digits_after_colon_q <= '0;
			colon_seconds_q      <= '0;
			colon_bad_q          <= 1'b0;
			group_value_q        <= '0;
			group_has_digit_q    <= 1'b0;
			unit_minutes_q       <= '0;
			unit_seconds_q       <= '0;
			seen_min_q           <= 1'b0;
			seen_sec_q           <= 1'b0;
			unit_bad_q           <= 1'b0;
		end else begin
			colon_minutes_q      <= colon_minutes_d;
			colon_seen_q         <= colon_seen_d;
			digits_after_colon_q <= digits_after_colon_d;
			colon_seconds_q      <= colon_seconds_d;
			colon_bad_q          <= colon_bad_d;
			group_value_q        <= group_value_d;
			group_has_digit_q    <= group_has_digit_d;
			unit_minutes_q       <= unit_minutes_d;
			unit_seconds_q       <= unit_seconds_d;
			seen_min_q           <= seen_min_d;
			seen_sec_q           <= seen_sec_d;
			unit_bad_q           <= unit_bad_d;
		end
	end

	// result register control: loaded by an end item, emptied by a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take_end) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (take_end) begin
			result_q <= result_d;
		end
	end

	// an end item always lands in the result register
	`DTP_ASSERT_NXT(a_end_loads_result, clk, arst_n, take_end, result_valid_q)
	// parse state is clear after an end item
	`DTP_ASSERT_NXT(a_end_clears_state, clk, arst_n, take_end,
		!colon_seen_q && !group_has_digit_q && !unit_bad_q && digits_after_colon_q == 2'd0)
	// seconds digits are only counted once a colon has been seen
	`DTP_ASSERT_IMP(a_digits_need_colon, clk, arst_n, digits_after_colon_q != 2'd0,
		colon_seen_q)
	// a rejected text always carries the sentinel
	`DTP_ASSERT_IMP(a_invalid_sentinel, clk, arst_n, result_valid_q && !result_q.valid_res,
		result_q.total_seconds == dtp_pkg::MAX_SECONDS)

endmodule
